// File: rtl/ttrgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttrgb_pkg
// Shared types and constants for the tone to normalized color block.
// ----------------------------------------------------------------------------
package ttrgb_pkg;

  // channel sums and derived widths
  localparam int unsigned SUM_W   = 21;
  localparam int unsigned AMP_W   = 16;
  localparam int unsigned NORM_W  = 2 * SUM_W + 2;   // sum of three squares
  localparam int unsigned SCL_W   = SUM_W + 8;       // channel times full scale
  localparam int unsigned MA_W    = NORM_W;          // multiplicand width
  localparam int unsigned MB_W    = SCL_W;           // multiplier width
  localparam int unsigned PROD_W  = 60;              // widest product
  localparam int unsigned COLOR_W = 8;

  // semitone codes that contribute
  localparam logic [3:0] TONE_C = 4'd0;
  localparam logic [3:0] TONE_D = 4'd2;
  localparam logic [3:0] TONE_E = 4'd4;
  localparam logic [3:0] TONE_F = 4'd5;
  localparam logic [3:0] TONE_G = 4'd7;
  localparam logic [3:0] TONE_A = 4'd9;
  localparam logic [3:0] TONE_B = 4'd11;

  // channel indexes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef struct packed {
    logic [3:0]       tone;
    logic [AMP_W-1:0] amplitude;
    logic             frame_end;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               silent;
  } out_item_t;

  // serial multiplier command and status
  typedef struct packed {
    logic            start;
    logic            accum;
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
  } smul_cmd_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } smul_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM_LD,
    ST_NORM_RUN,
    ST_TGT_LD,
    ST_TGT_RUN,
    ST_TRY_LD,
    ST_TRY_RUN,
    ST_DONE
  } ttrgb_state_e;

endpackage

// File: rtl/ttrgb_smul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttrgb_smul
// Shift-and-add multiplier: one multiplier bit per cycle, stops as soon as
// the remaining multiplier bits are all zero.
// ----------------------------------------------------------------------------
module ttrgb_smul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ttrgb_pkg::smul_cmd_t cmd_i,
  output ttrgb_pkg::smul_sts_t sts_o
);
  import ttrgb_pkg::*;

  logic              busy_q, busy_d;
  logic [PROD_W-1:0] a_q, a_d;
  logic [MB_W-1:0]   b_q, b_d;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic              fin;

  assign fin = busy_q && (b_q == '0);

  // next values of the shift registers and accumulator
  always_comb begin
    busy_d = busy_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      a_d    = PROD_W'(cmd_i.a);
      b_d    = cmd_i.b;
      acc_d  = cmd_i.accum ? acc_q : '0;
    end else if (fin) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_d = acc_q + a_q;
      end
      a_d = {a_q[PROD_W-2:0], 1'b0};
      b_d = {1'b0, b_q[MB_W-1:1]};
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign sts_o.done = fin;
  assign sts_o.prod = acc_q;

endmodule

// File: rtl/tone_to_normalized_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tone_to_normalized_rgb
// Weights tone amplitudes into red, green and blue sums and, at the end of
// each frame, emits the color scaled to a unit vector times 255.
// ----------------------------------------------------------------------------
// A tone item is taken in any cycle in which the block is idle. The item
// that closes a frame starts the normalization, which runs on one shared
// shift-and-add multiplier retiring one multiplier bit per cycle: three
// squares for the norm, then per channel one square of channel times 255
// and eight trial products of the candidate squared times the norm. No
// item is taken until the color has moved into the output register. The
// finished color sits in that output register, so the next frame can
// begin while it waits to be taken. An all-zero frame gives black with
// silent set.
// ----------------------------------------------------------------------------
module tone_to_normalized_rgb (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  ttrgb_pkg::in_item_t  in_data_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  output ttrgb_pkg::out_item_t out_data_o,
  input  logic                 out_stall_i
);
  import ttrgb_pkg::*;

  ttrgb_state_e state_q, state_d;

  logic [SUM_W-1:0]   red_sum_q, green_sum_q, blue_sum_q;
  logic [NORM_W-1:0]  norm2_q;
  logic [PROD_W-1:0]  target_q;
  logic [1:0]         ch_q;
  logic [2:0]         bit_q;
  logic [COLOR_W-1:0] q_q;
  logic [COLOR_W-1:0] red_q, green_q, blue_q;
  logic               out_valid_q;
  out_item_t          out_q;

  smul_cmd_t          mul_cmd;
  smul_sts_t          mul_sts;

  logic               in_fire;
  logic               out_load;
  logic [SUM_W-1:0]   ch_sum;
  logic [SCL_W-1:0]   ch_scaled;
  logic [COLOR_W-1:0] trial;
  logic [15:0]        trial_sq;
  logic               fits;
  logic [AMP_W:0]     addend;
  logic [1:0]         add_ch;
  logic               add_en;
  logic [SUM_W:0]     add_sum;
  logic [SUM_W-1:0]   add_sat;

  // shared multiplier
  ttrgb_smul u_smul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mul_cmd),
    .sts_o  (mul_sts)
  );

  // operand selection
  always_comb begin
    unique case (ch_q)
      CH_RED:   ch_sum = red_sum_q;
      CH_GREEN: ch_sum = green_sum_q;
      default:  ch_sum = blue_sum_q;
    endcase
  end

  assign ch_scaled = {ch_sum, 8'b0} - SCL_W'(ch_sum);
  assign trial     = q_q | (COLOR_W'(1) << bit_q);
  assign trial_sq  = 16'(trial) * 16'(trial);
  assign fits      = mul_sts.prod <= target_q;

  // tone weighting
  always_comb begin
    add_en = 1'b1;
    add_ch = CH_RED;
    addend = {in_data_i.amplitude, 1'b0};
    unique case (in_data_i.tone)
      TONE_C, TONE_B: begin
        add_ch = CH_RED;
      end
      TONE_D: begin
        add_ch = CH_RED;
        addend = {1'b0, in_data_i.amplitude};
      end
      TONE_E: begin
        add_ch = CH_GREEN;
      end
      TONE_F: begin
        add_ch = CH_GREEN;
        addend = {1'b0, in_data_i.amplitude};
      end
      TONE_G: begin
        add_ch = CH_BLUE;
      end
      TONE_A: begin
        add_ch = CH_BLUE;
        addend = {1'b0, in_data_i.amplitude};
      end
      default: begin
        add_en = 1'b0;
      end
    endcase
  end

  // saturating accumulate
  always_comb begin
    unique case (add_ch)
      CH_RED:   add_sum = {1'b0, red_sum_q} + (SUM_W+1)'(addend);
      CH_GREEN: add_sum = {1'b0, green_sum_q} + (SUM_W+1)'(addend);
      default:  add_sum = {1'b0, blue_sum_q} + (SUM_W+1)'(addend);
    endcase
    add_sat = add_sum[SUM_W] ? '1 : add_sum[SUM_W-1:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_data_i.frame_end) begin
          state_d = ST_NORM_LD;
        end
      end
      ST_NORM_LD: state_d = ST_NORM_RUN;
      ST_NORM_RUN: begin
        if (mul_sts.done) begin
          if (ch_q != CH_BLUE) begin
            state_d = ST_NORM_LD;
          end else if (mul_sts.prod == '0) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_TGT_LD;
          end
        end
      end
      ST_TGT_LD: state_d = ST_TGT_RUN;
      ST_TGT_RUN: begin
        if (mul_sts.done) begin
          state_d = ST_TRY_LD;
        end
      end
      ST_TRY_LD: state_d = ST_TRY_RUN;
      ST_TRY_RUN: begin
        if (mul_sts.done) begin
          if (bit_q != '0) begin
            state_d = ST_TRY_LD;
          end else if (ch_q == CH_BLUE) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_TGT_LD;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o    = 1'b1;
    out_load      = 1'b0;
    mul_cmd.start = 1'b0;
    mul_cmd.accum = 1'b0;
    mul_cmd.a     = MA_W'(ch_sum);
    mul_cmd.b     = MB_W'(ch_sum);
    unique case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_NORM_LD: begin
        mul_cmd.start = 1'b1;
        mul_cmd.accum = ch_q != CH_RED;
      end
      ST_TGT_LD: begin
        mul_cmd.start = 1'b1;
        mul_cmd.a     = MA_W'(ch_scaled);
        mul_cmd.b     = ch_scaled;
      end
      ST_TRY_LD: begin
        mul_cmd.start = 1'b1;
        mul_cmd.a     = norm2_q;
        mul_cmd.b     = MB_W'(trial_sq);
      end
      ST_DONE: out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  assign in_fire = in_valid_i && (state_q == ST_IDLE);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      red_sum_q   <= '0;
      green_sum_q <= '0;
      blue_sum_q  <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (out_load) begin
        red_sum_q   <= '0;
        green_sum_q <= '0;
        blue_sum_q  <= '0;
      end else if (in_fire && add_en) begin
        unique case (add_ch)
          CH_RED:   red_sum_q   <= add_sat;
          CH_GREEN: green_sum_q <= add_sat;
          default:  blue_sum_q  <= add_sat;
        endcase
      end
    end
  end

  // normalization datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        ch_q <= CH_RED;
      end
      ST_NORM_RUN: begin
        if (mul_sts.done) begin
          if (ch_q == CH_BLUE) begin
            norm2_q <= mul_sts.prod[NORM_W-1:0];
            ch_q    <= CH_RED;
          end else begin
            ch_q <= ch_q + 2'd1;
          end
        end
      end
      ST_TGT_RUN: begin
        if (mul_sts.done) begin
          target_q <= mul_sts.prod;
          q_q      <= '0;
          bit_q    <= '1;
        end
      end
      ST_TRY_RUN: begin
        if (mul_sts.done) begin
          if (fits) begin
            q_q <= trial;
          end
          if (bit_q == '0) begin
            unique case (ch_q)
              CH_RED:   red_q   <= fits ? trial : q_q;
              CH_GREEN: green_q <= fits ? trial : q_q;
              default:  blue_q  <= fits ? trial : q_q;
            endcase
            ch_q <= ch_q + 2'd1;
          end else begin
            bit_q <= bit_q - 3'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.silent <= norm2_q == '0;
      out_q.red    <= (norm2_q == '0) ? '0 : red_q;
      out_q.green  <= (norm2_q == '0) ? '0 : green_q;
      out_q.blue   <= (norm2_q == '0) ? '0 : blue_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: test/tone_to_normalized_rgb_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tone_to_normalized_rgb_tb
// Self-checking bench for the tone to normalized color block. Tone frames
// are queued by an initial block and fed by a clocked driver with random
// gaps. A clocked monitor keeps its own weighted channel sums, works out the
// normalized color at every frame end and compares each color transfer
// against the oldest expected color.
// ----------------------------------------------------------------------------
module tone_to_normalized_rgb_tb;
  import ttrgb_pkg::*;

  localparam int unsigned IDLE_PCT    = 28;
  localparam int unsigned RAND_ITEMS  = 1600;
  localparam int unsigned CALM_LO     = 700;
  localparam int unsigned CALM_HI     = 1000;
  localparam int unsigned TAIL_CYCLES = 1200;
  localparam int unsigned CYCLE_LIMIT = 5000000;
  localparam logic [SUM_W-1:0]  SUM_FULL = {SUM_W{1'b1}};
  localparam logic [AMP_W-1:0]  AMP_FULL = {AMP_W{1'b1}};
  localparam logic [63:0]       FULL_SQ  = 64'd65025;

  typedef struct {
    in_item_t item;
    bit       drain;
  } tone_slot_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  in_item_t  in_data;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;
  logic      out_stall;

  tone_slot_t tone_q[$];
  out_item_t  color_q[$];

  logic [SUM_W-1:0] red_acc;
  logic [SUM_W-1:0] green_acc;
  logic [SUM_W-1:0] blue_acc;

  logic      in_taken;
  logic      calm;
  out_item_t want;
  int        sent_cnt;
  int        err_cnt;
  int        frame_cnt;
  int        silent_cnt;
  int        sat_cnt;
  int        color_cnt;
  int        cycle_cnt;

  tone_to_normalized_rgb dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_data_i   (in_data),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .out_stall_i (out_stall)
  );

  // no idling on either side for a stretch in the middle of the run
  assign calm = (sent_cnt >= CALM_LO) && (sent_cnt < CALM_HI);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // saturating channel add
  function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] acc, logic [SUM_W:0] v);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + v;
    return (s > {1'b0, SUM_FULL}) ? SUM_FULL : s[SUM_W-1:0];
  endfunction

  // largest q with q*q*norm2 <= 65025*c*c, bit by bit from the top
  function automatic logic [COLOR_W-1:0] unit_scale(logic [SUM_W-1:0] c, logic [63:0] norm2);
    logic [63:0] target;
    logic [63:0] q;
    logic [63:0] t;
    target = FULL_SQ * {43'd0, c} * {43'd0, c};
    q = 64'd0;
    for (int b = COLOR_W - 1; b >= 0; b--) begin
      t = q | (64'd1 << b);
      if (t * t * norm2 <= target) q = t;
    end
    return q[COLOR_W-1:0];
  endfunction

  // fold one accepted tone into the channel sums, emit the color at frame end
  task automatic absorb_tone(in_item_t it);
    logic [SUM_W:0] twice;
    logic [SUM_W:0] once;
    logic [63:0]    norm2;
    out_item_t      px;
    twice = {{(SUM_W - AMP_W){1'b0}}, it.amplitude, 1'b0};
    once  = {{(SUM_W - AMP_W + 1){1'b0}}, it.amplitude};
    case (it.tone)
      TONE_C, TONE_B: red_acc   = sat_add(red_acc, twice);
      TONE_D:         red_acc   = sat_add(red_acc, once);
      TONE_E:         green_acc = sat_add(green_acc, twice);
      TONE_F:         green_acc = sat_add(green_acc, once);
      TONE_G:         blue_acc  = sat_add(blue_acc, twice);
      TONE_A:         blue_acc  = sat_add(blue_acc, once);
      default: ;
    endcase
    if (it.frame_end) begin
      norm2 = {43'd0, red_acc} * {43'd0, red_acc} + {43'd0, green_acc} * {43'd0, green_acc}
            + {43'd0, blue_acc} * {43'd0, blue_acc};
      if (norm2 == 64'd0) begin
        px = '{red: '0, green: '0, blue: '0, silent: 1'b1};
        silent_cnt++;
      end else begin
        px.red    = unit_scale(red_acc, norm2);
        px.green  = unit_scale(green_acc, norm2);
        px.blue   = unit_scale(blue_acc, norm2);
        px.silent = 1'b0;
      end
      if (red_acc == SUM_FULL || green_acc == SUM_FULL || blue_acc == SUM_FULL) sat_cnt++;
      color_q.push_back(px);
      frame_cnt++;
      red_acc   = '0;
      green_acc = '0;
      blue_acc  = '0;
    end
  endtask

  task automatic queue_tone(logic [3:0] tn, logic [AMP_W-1:0] amp, logic last, bit drain = 0);
    tone_slot_t s;
    s.item.tone      = tn;
    s.item.amplitude = amp;
    s.item.frame_end = last;
    s.drain          = drain;
    tone_q.push_back(s);
  endtask

  function automatic logic [3:0] pick_tone();
    logic [3:0] used[7];
    used = '{TONE_C, TONE_D, TONE_E, TONE_F, TONE_G, TONE_A, TONE_B};
    if ($urandom_range(0, 99) < 80) return used[$urandom_range(0, 6)];
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [AMP_W-1:0] pick_amp();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return AMP_FULL;
    if (r < 40) return AMP_W'($urandom_range(0, 255));
    return AMP_W'($urandom);
  endfunction

  // driver: new tone transfer at the falling edge once the previous one is taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || in_taken) begin
        if (tone_q.size() != 0 && !(tone_q[0].drain && color_q.size() != 0) &&
            (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_data  <= tone_q[0].item;
          in_valid <= 1'b1;
          void'(tone_q.pop_front());
          sent_cnt++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // monitor: predict on each tone transfer, check each color transfer
  always @(posedge clk_i) begin
    in_taken <= in_valid && !in_stall;
    if (rst_ni) begin
      if (in_valid && !in_stall) absorb_tone(in_data);
      if (out_valid && !out_stall) begin
        color_cnt++;
        if (color_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected color r=%0d g=%0d b=%0d silent=%0b", $time,
                   out_data.red, out_data.green, out_data.blue, out_data.silent);
        end else begin
          want = color_q.pop_front();
          if (out_data !== want) begin
            err_cnt++;
            $display("%0t: color mismatch expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                     $time, want.red, want.green, want.blue, want.silent,
                     out_data.red, out_data.green, out_data.blue, out_data.silent);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int rand_cnt;
    int len;
    int r;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    in_taken   = 1'b0;
    red_acc    = '0;
    green_acc  = '0;
    blue_acc   = '0;
    sent_cnt   = 0;
    err_cnt    = 0;
    frame_cnt  = 0;
    silent_cnt = 0;
    sat_cnt    = 0;
    color_cnt  = 0;
    cycle_cnt  = 0;
    rst_ni     = 1'b0;

    // ignored tone still closes a frame, giving silence
    queue_tone(4'd1, AMP_FULL, 1'b1);
    // each contributing tone alone
    queue_tone(TONE_C, AMP_FULL, 1'b1);
    queue_tone(TONE_D, 16'd1, 1'b1);
    queue_tone(TONE_E, AMP_FULL, 1'b1);
    queue_tone(TONE_F, 16'd1, 1'b1);
    queue_tone(TONE_G, AMP_FULL, 1'b1);
    queue_tone(TONE_A, 16'h8000, 1'b1);
    queue_tone(TONE_B, AMP_FULL, 1'b1);
    // zero amplitude frame
    queue_tone(TONE_C, '0, 1'b1);
    // only ignored tones, full amplitude
    queue_tone(4'd12, AMP_FULL, 1'b0);
    queue_tone(4'd13, AMP_FULL, 1'b0);
    queue_tone(4'd14, AMP_FULL, 1'b0);
    queue_tone(4'd15, AMP_FULL, 1'b0);
    queue_tone(4'd3, AMP_FULL, 1'b0);
    queue_tone(4'd6, AMP_FULL, 1'b0);
    queue_tone(4'd8, AMP_FULL, 1'b0);
    queue_tone(4'd10, AMP_FULL, 1'b1);
    // equal channels, closed by an ignored tone
    queue_tone(TONE_C, AMP_FULL, 1'b0);
    queue_tone(TONE_E, AMP_FULL, 1'b0);
    queue_tone(TONE_G, AMP_FULL, 1'b0);
    queue_tone(4'd10, AMP_FULL, 1'b1);
    // single weights on red and blue
    queue_tone(TONE_A, AMP_FULL, 1'b0);
    queue_tone(TONE_D, AMP_FULL, 1'b1);

    // longest frame without overflow, then one that saturates
    for (int i = 0; i < 16; i++) queue_tone(TONE_C, AMP_FULL, i == 15, i == 0);
    for (int i = 0; i < 17; i++) queue_tone(TONE_B, AMP_FULL, i == 16);

    // random frames, mostly short, a few long enough to saturate
    rand_cnt = 0;
    while (rand_cnt < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 8);
      else if (r < 92) len = $urandom_range(9, 16);
      else len = $urandom_range(17, 40);
      for (int i = 0; i < len; i++) begin
        queue_tone(pick_tone(), pick_amp(), i == len - 1,
                   (rand_cnt + i == RAND_ITEMS / 2));
      end
      rand_cnt += len;
    end

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    while (tone_q.size() != 0 || in_valid) @(posedge clk_i);
    while (color_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d tone transfers, %0d frames (%0d silent, %0d saturated), %0d colors checked",
             sent_cnt, frame_cnt, silent_cnt, sat_cnt, color_cnt);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d errors", err_cnt);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
